// ----- sv/stsp_pkg.sv -----
// Shared types and constants for the sinusoidal trajectory setpoint block.
// Holds the fixed-point formats, the CORDIC angle table and the register map.
// No dependencies; every other file in sv/ imports this package.
package stsp_pkg;

    // Phase and sine resolution
    localparam int PHASE_BITS   = 16;
    localparam int SINE_BITS    = 16;

    // CORDIC datapath: Q30 values with headroom for growth and sign
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam int SINE_SH      = 31 - SINE_BITS;

    // Axis product and sum widths
    localparam int PROD_W       = 32 + SINE_BITS;
    localparam int SUM_W        = 35;

    // Queue between the front and the back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Configuration index width (one spare bit so out-of-map writes are visible)
    localparam int CFG_IDX_W    = 4;

    typedef logic [31:0]          t_word;
    typedef logic signed [CW-1:0] t_cval;

    // 1/K pre-scaled start vector, Q30
    localparam t_cval CORDIC_GAIN = t_cval'(652032874);

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5,         32'd3,        32'd1
    };

    // Sine rounding and clamp limits
    localparam t_cval Y_HALF  = t_cval'(1) <<< (SINE_SH - 1);
    localparam t_cval SINE_HI = (t_cval'(1) <<< (SINE_BITS - 1)) - t_cval'(1);
    localparam t_cval SINE_LO = -(t_cval'(1) <<< (SINE_BITS - 1));

    // Axis rounding and output clamp limits
    localparam logic signed [PROD_W:0]  MUL_HALF = (PROD_W + 1)'(1) <<< (SINE_BITS - 2);
    localparam logic signed [SUM_W-1:0] POS_HI   = SUM_W'(32'sh7fff_ffff);
    localparam logic signed [SUM_W-1:0] POS_LO   = SUM_W'(32'sh8000_0000);

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_AMPLITUDE_X,
        REG_AMPLITUDE_Y,
        REG_AMPLITUDE_Z,
        REG_FREQUENCY,
        REG_PERIOD_COUNT
    } t_reg_idx;

    // Register file contents
    typedef struct packed {
        t_word [2:0] center;
        t_word [2:0] amp;
        t_word       freq;
        logic [15:0] pcount;
    } t_cfg;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic                  moving;
        logic [PHASE_BITS-1:0] phase;
    } t_cls;

endpackage

// ----- sv/stsp_front.sv -----
// Front end: accepts time samples, forms cycles = frequency * time, and
// classifies each request (moving or at center, phase of the turn).
// Depends on stsp_pkg.
module stsp_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [31:0]           i_time_now,
    input  stsp_pkg::t_cfg               i_cfg,
    input  logic [stsp_pkg::QCNT_W-1:0]  i_level,
    output logic                         o_push,
    output stsp_pkg::t_cls               o_cls
);
    import stsp_pkg::*;

    logic               r_valid;
    logic signed [63:0] r_prod;
    logic signed [64:0] n_prod;
    logic               accept;

    // Credit check: queue entries plus the request in the multiply stage
    assign o_ready = (int'(i_level) + int'(r_valid)) < QUEUE_DEPTH;
    assign accept  = i_valid && o_ready;

    // Unsigned Q8.24 times signed Q16.16 gives signed Q24.40
    assign n_prod = $signed({1'b0, i_cfg.freq}) * i_time_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= n_prod[63:0];
        end
    end

    // Moving while the frequency is nonzero and the whole-cycle count is below period_count
    assign o_push       = r_valid;
    assign o_cls.moving = (i_cfg.freq != '0) &&
                          ($signed(r_prod[63:40]) < $signed({8'b0, i_cfg.pcount}));
    assign o_cls.phase  = r_prod[39 -: PHASE_BITS];

endmodule

// ----- sv/stsp_queue.sv -----
// Short request queue between the front and the back.
// Register-based, first in first out. Depends on stsp_pkg.
module stsp_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  stsp_pkg::t_cls               i_data,
    input  logic                         i_pop,
    output stsp_pkg::t_cls               o_data,
    output logic                         o_empty,
    output logic [stsp_pkg::QCNT_W-1:0]  o_level
);
    import stsp_pkg::*;

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_level = r_count;

    // The front's credit check must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QCNT_W'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule

// ----- sv/stsp_back.sv -----
// Back end: phase fold, pipelined CORDIC sine, per-axis scale and offset
// with saturation, and the output register. Depends on stsp_pkg.
module stsp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stsp_pkg::t_cfg       i_cfg,
    input  stsp_pkg::t_cls       i_head,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output stsp_pkg::t_word      o_pos [3]
);
    import stsp_pkg::*;

    // Stall control: the whole back advances when the output slot frees
    logic en;

    // Fold stage
    logic [31:0] fold_u;
    logic [31:0] fold_chk;
    logic        fold_flip;
    logic [31:0] fold_z;

    // CORDIC stages: index 0 is the folded start, index k is after k rotations
    t_cval                 r_x    [CORDIC_STEPS+1];
    t_cval                 r_y    [CORDIC_STEPS+1];
    t_cval                 r_z    [CORDIC_STEPS+1];
    t_cval                 n_x    [CORDIC_STEPS+1];
    t_cval                 n_y    [CORDIC_STEPS+1];
    t_cval                 n_z    [CORDIC_STEPS+1];
    logic [CORDIC_STEPS:0] r_flip;
    logic [CORDIC_STEPS:0] r_mov;
    logic [CORDIC_STEPS:0] r_vld;

    // Sine round and clamp stage
    t_cval                        yf;
    t_cval                        yr;
    logic signed [SINE_BITS-1:0]  n_sin;
    logic signed [SINE_BITS-1:0]  r_sin;
    logic                         r_mov_s;
    logic                         r_vld_s;

    // Multiply stage
    logic signed [PROD_W-1:0] n_mul [3];
    logic signed [PROD_W-1:0] r_mul [3];
    logic                     r_mov_m;
    logic                     r_vld_m;

    // Output stage
    logic signed [PROD_W:0]    rnd  [3];
    logic signed [SUM_W-1:0]   sum  [3];
    t_word                     n_pos [3];
    t_word                     r_pos [3];
    logic                      r_out_valid;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_empty;

    // Half-turn fold into [-1/4, 1/4) turn
    assign fold_u    = {i_head.phase, {(32 - PHASE_BITS){1'b0}}};
    assign fold_chk  = fold_u + 32'h4000_0000;
    assign fold_flip = fold_chk[31];
    assign fold_z    = fold_flip ? (fold_u ^ 32'h8000_0000) : fold_u;

    // Rotation steps, one per stage
    always_comb begin
        n_x[0] = CORDIC_GAIN;
        n_y[0] = '0;
        n_z[0] = t_cval'($signed(fold_z));
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (!r_z[k][CW-1]) begin
                n_x[k+1] = r_x[k] - (r_y[k] >>> k);
                n_y[k+1] = r_y[k] + (r_x[k] >>> k);
                n_z[k+1] = r_z[k] - t_cval'(ATAN_TURN[k]);
            end else begin
                n_x[k+1] = r_x[k] + (r_y[k] >>> k);
                n_y[k+1] = r_y[k] - (r_x[k] >>> k);
                n_z[k+1] = r_z[k] + t_cval'(ATAN_TURN[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k <= CORDIC_STEPS; k++) begin
                r_x[k] <= n_x[k];
                r_y[k] <= n_y[k];
                r_z[k] <= n_z[k];
            end
            r_flip <= {r_flip[CORDIC_STEPS-1:0], fold_flip};
            r_mov  <= {r_mov[CORDIC_STEPS-1:0], i_head.moving};
        end
    end

    // Undo the fold, round half up to Q1.(SINE_BITS-1), clamp
    always_comb begin
        yf = r_flip[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        yr = (yf + Y_HALF) >>> SINE_SH;
        if (yr > SINE_HI) begin
            n_sin = SINE_BITS'(SINE_HI);
        end else if (yr < SINE_LO) begin
            n_sin = SINE_BITS'(SINE_LO);
        end else begin
            n_sin = SINE_BITS'(yr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sin   <= n_sin;
            r_mov_s <= r_mov[CORDIC_STEPS];
        end
    end

    // Amplitude times sine, one multiplier per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_mul[a] = $signed(i_cfg.amp[a]) * r_sin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mul   <= n_mul;
            r_mov_m <= r_mov_s;
        end
    end

    // Round, add the center, saturate; a request that is not moving gives the center
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rnd[a] = ($signed({r_mul[a][PROD_W-1], r_mul[a]}) + MUL_HALF) >>> (SINE_BITS - 1);
            sum[a] = SUM_W'($signed(i_cfg.center[a])) + SUM_W'(rnd[a]);
            if (!r_mov_m) begin
                n_pos[a] = i_cfg.center[a];
            end else if (sum[a] > POS_HI) begin
                n_pos[a] = 32'h7fff_ffff;
            end else if (sum[a] < POS_LO) begin
                n_pos[a] = 32'h8000_0000;
            end else begin
                n_pos[a] = sum[a][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos <= n_pos;
        end
    end

    // Valid bits along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_vld_s     <= 1'b0;
            r_vld_m     <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[CORDIC_STEPS-1:0], !i_empty};
            r_vld_s     <= r_vld[CORDIC_STEPS];
            r_vld_m     <= r_vld_s;
            r_out_valid <= r_vld_m;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pos   = r_pos;

    // A held result freezes every stage behind it
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> ($stable(r_vld) && $stable(r_vld_s) && $stable(r_vld_m)))
        else $error("pipeline moved while output stalled");

    // A result only appears from an occupied multiply stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld_m))
        else $error("output valid without a request behind it");

endmodule

// ----- sv/sine_trajectory_setpoint.sv -----
// Top level of the 3-axis sinusoidal trajectory setpoint generator.
// Holds the register file and connects stsp_front, stsp_queue and stsp_back.
// Depends on stsp_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_time_now): one time sample,
//   signed Q16.16 seconds, per request.
//   Output channel (o_out_valid / i_out_ready / o_pos_x, o_pos_y, o_pos_z):
//   one signed Q16.16 setpoint per axis for each sample, in order.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   writes one register per request; o_cfg_ready is always high. Indexes
//   beyond the register map are ignored. Write only while the block is idle.
//   An accepted sample passes, in order: 1 multiply stage, 1 queue stage,
//   fold, 30 CORDIC stages, sine round, axis multiply and the output
//   register, which drives o_out_valid.
//   Throughput: one sample per cycle while i_out_ready stays high; each
//   CORDIC rotation has its own pipeline stage.
//   Reset clears all configuration registers to zero and empties the pipeline and queue.
//   When the receiver stalls, the back pipeline holds in place; the 4-entry
//   queue absorbs requests until o_in_ready drops.
module sine_trajectory_setpoint (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // time samples in
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [31:0]               i_time_now,
    // setpoints out
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [31:0]               o_pos_x,
    output logic signed [31:0]               o_pos_y,
    output logic signed [31:0]               o_pos_z,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [stsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                      i_cfg_data
);
    import stsp_pkg::*;

    t_cfg              r_cfg;
    logic              push;
    t_cls              push_cls;
    logic              pop;
    t_cls              head;
    logic              empty;
    logic [QCNT_W-1:0] level;
    t_word             pos [3];

    // Register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_CENTER_X:     r_cfg.center[0] <= i_cfg_data;
                REG_CENTER_Y:     r_cfg.center[1] <= i_cfg_data;
                REG_CENTER_Z:     r_cfg.center[2] <= i_cfg_data;
                REG_AMPLITUDE_X:  r_cfg.amp[0]    <= i_cfg_data;
                REG_AMPLITUDE_Y:  r_cfg.amp[1]    <= i_cfg_data;
                REG_AMPLITUDE_Z:  r_cfg.amp[2]    <= i_cfg_data;
                REG_FREQUENCY:    r_cfg.freq      <= i_cfg_data;
                REG_PERIOD_COUNT: r_cfg.pcount    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    stsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_time_now (i_time_now),
        .i_cfg      (r_cfg),
        .i_level    (level),
        .o_push     (push),
        .o_cls      (push_cls)
    );

    stsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cls),
        .i_pop   (pop),
        .o_data  (head),
        .o_empty (empty),
        .o_level (level)
    );

    stsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_pos   (pos)
    );

    assign o_pos_x = $signed(pos[0]);
    assign o_pos_y = $signed(pos[1]);
    assign o_pos_z = $signed(pos[2]);

endmodule
